/* design/gcll_pkg.sv */
// shared types, command codes and constants of the cluster log-likelihood block
`default_nettype none
package gcll_pkg;

  // command codes
  localparam logic [2:0] CMD_LOAD_FACTOR = 3'd0;
  localparam logic [2:0] CMD_LOAD_MEAN   = 3'd1;
  localparam logic [2:0] CMD_LOAD_OFFSET = 3'd2;
  localparam logic [2:0] CMD_POINT       = 3'd3;
  localparam logic [2:0] CMD_EVAL        = 3'd4;

  // fault codes
  localparam logic [1:0] FAULT_OK       = 2'd0;
  localparam logic [1:0] FAULT_ZERO_DIAG = 2'd1;
  localparam logic [1:0] FAULT_SAT      = 2'd2;

  // register indexes
  localparam logic [1:0] REG_NUM_DIMS    = 2'd0;
  localparam logic [1:0] REG_DIST_THRESH = 2'd1;
  localparam logic [1:0] REG_FULL_STEP   = 2'd2;
  localparam logic [1:0] REG_LOG_TWO_PI  = 2'd3;

  // q16.16 limits
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // input beat
  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         cluster;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic signed [31:0] prev_self;
    logic signed [31:0] prev_best;
    logic               class_unchanged;
  } item_t;

  // result beat
  typedef struct packed {
    logic [3:0]         cluster_out;
    logic signed [31:0] logp;
    logic               skipped;
    logic [1:0]         fault;
  } result_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic [62:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic        done;
    logic [62:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* design/gaussian_cluster_log_likelihood_top.sv */
// top level: config registers, tables, sequencer and shared multiply/divide datapath
// loads give no result; a skipped evaluate gives its result in the cycle after
// acceptance and a zero-dimension evaluate gives it from the final state; a full
// evaluate runs every row through the bit-serial divider and the multiplier;
// busy_o is high meanwhile
// results are strobed for one cycle and cannot be stalled; async active-low reset
// clears control state and config registers, tables are undefined until written
`default_nettype none
module gaussian_cluster_log_likelihood_top #(
  parameter int MAX_DIM     = 16,
  parameter int MAX_CLUSTER = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire gcll_pkg::item_t   item_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output gcll_pkg::result_t      result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  import gcll_pkg::*;

  localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IW  = $clog2(MAX_DIM + 1);
  localparam int FD  = MAX_CLUSTER * MAX_DIM * MAX_DIM;
  localparam int MD  = MAX_CLUSTER * MAX_DIM;
  localparam int FAW = $clog2(FD);
  localparam int MAW = $clog2(MD);
  localparam int CW  = $clog2(MAX_CLUSTER);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ROW  = 4'd1;
  localparam logic [3:0] ST_ROWD = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_SQ   = 4'd7;
  localparam logic [3:0] ST_SQM  = 4'd8;
  localparam logic [3:0] ST_SQA  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  localparam logic signed [55:0] S_MAX = 56'sd70368744177663;
  localparam logic signed [55:0] S_MIN = -56'sd70368744177664;

  // configuration registers
  logic [4:0]         num_dims_q;
  logic signed [31:0] dist_thresh_q;
  logic               full_step_q;
  logic signed [31:0] l2p_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q    <= 5'd16;
      dist_thresh_q <= '0;
      full_step_q   <= 1'b1;
      l2p_q         <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_NUM_DIMS:    num_dims_q    <= pwdata[4:0];
        REG_DIST_THRESH: dist_thresh_q <= pwdata;
        REG_FULL_STEP:   full_step_q   <= pwdata[0];
        REG_LOG_TWO_PI:  l2p_q         <= pwdata;
        default:         ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_NUM_DIMS:    prdata = {27'd0, num_dims_q};
      REG_DIST_THRESH: prdata = dist_thresh_q;
      REG_FULL_STEP:   prdata = {31'd0, full_step_q};
      REG_LOG_TWO_PI:  prdata = l2p_q;
      default:         prdata = '0;
    endcase
  end

  // sequencer and datapath state
  logic [3:0]         st_q, st_d;
  logic [3:0]         cl_q;
  logic [IW-1:0]      i_q, i_d, j_q, j_d, n_w;
  logic signed [55:0] acc_q, acc_d;
  logic signed [31:0] diag_q, diag_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] r_q, r_d;
  logic [54:0]        mahal_q, mahal_d;
  logic               sat_q, sat_d;
  logic               neg_q, neg_d;
  logic               rv_q, rv_d;
  result_t            res_q, res_d;

  logic accept, is_eval, do_skip, in_range;
  logic signed [32:0] self_gap;

  assign busy_o = (st_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign n_w    = (32'(num_dims_q) > MAX_DIM) ? IW'(MAX_DIM) : IW'(num_dims_q);
  assign in_range = 32'(item_i.cluster) < MAX_CLUSTER;
  assign is_eval  = accept && (item_i.cmd == CMD_EVAL) && in_range;
  assign self_gap = 33'(item_i.prev_self) - 33'(item_i.prev_best);
  assign do_skip  = !full_step_q && item_i.class_unchanged &&
                    (self_gap > 33'(dist_thresh_q));

  // table write strobes
  logic fac_we, mean_we, off_we, pt_we;
  assign fac_we  = accept && item_i.cmd == CMD_LOAD_FACTOR && in_range &&
                   32'(item_i.row) < MAX_DIM && 32'(item_i.col) < MAX_DIM;
  assign mean_we = accept && item_i.cmd == CMD_LOAD_MEAN && in_range &&
                   32'(item_i.row) < MAX_DIM;
  assign off_we  = accept && item_i.cmd == CMD_LOAD_OFFSET && in_range;
  assign pt_we   = accept && item_i.cmd == CMD_POINT && 32'(item_i.row) < MAX_DIM;

  // table read addresses
  logic [IW-1:0]  jsel;
  logic [FAW-1:0] fac_waddr, fac_raddr;
  logic [MAW-1:0] mean_waddr, mean_raddr;
  logic           rd_row, rd_pair;
  logic signed [31:0] fac_rd, mean_rd, off_rd, pt_rd, sol_rd;

  always_comb begin
    jsel = (st_q == ST_ROW) ? i_q : ((st_q == ST_ACC) ? IW'(j_q + 1'b1) : '0);
  end
  assign rd_row  = (st_q == ST_ROW);
  assign rd_pair = (st_q == ST_ROWD) || (st_q == ST_ACC);

  assign fac_waddr  = FAW'(item_i.cluster) * FAW'(MAX_DIM * MAX_DIM) +
                      FAW'(item_i.row) * FAW'(MAX_DIM) + FAW'(item_i.col);
  assign fac_raddr  = FAW'(cl_q) * FAW'(MAX_DIM * MAX_DIM) +
                      FAW'(i_q) * FAW'(MAX_DIM) + FAW'(jsel);
  assign mean_waddr = MAW'(item_i.cluster) * MAW'(MAX_DIM) + MAW'(item_i.row);
  assign mean_raddr = MAW'(cl_q) * MAW'(MAX_DIM) + MAW'(i_q);

  gcll_ram #(.Width(32), .Depth(FD)) u_factor (
    .clk_i, .we_i(fac_we), .waddr_i(fac_waddr), .wdata_i(item_i.value),
    .re_i(rd_row || rd_pair), .raddr_i(fac_raddr), .rdata_o(fac_rd)
  );

  gcll_ram #(.Width(32), .Depth(MD)) u_mean (
    .clk_i, .we_i(mean_we), .waddr_i(mean_waddr), .wdata_i(item_i.value),
    .re_i(rd_row), .raddr_i(mean_raddr), .rdata_o(mean_rd)
  );

  gcll_ram #(.Width(32), .Depth(MAX_CLUSTER)) u_offset (
    .clk_i, .we_i(off_we), .waddr_i(CW'(item_i.cluster)), .wdata_i(item_i.value),
    .re_i(is_eval), .raddr_i(CW'(item_i.cluster)), .rdata_o(off_rd)
  );

  gcll_ram #(.Width(32), .Depth(MAX_DIM)) u_point (
    .clk_i, .we_i(pt_we), .waddr_i(DW'(item_i.row)), .wdata_i(item_i.value),
    .re_i(rd_row), .raddr_i(i_q[DW-1:0]), .rdata_o(pt_rd)
  );

  gcll_ram #(.Width(32), .Depth(MAX_DIM)) u_solve (
    .clk_i, .we_i(st_q == ST_SQ), .waddr_i(i_q[DW-1:0]), .wdata_i(r_d),
    .re_i(rd_pair), .raddr_i(jsel[DW-1:0]), .rdata_o(sol_rd)
  );

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  gcll_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // clamp and magnitudes for the divide
  logic signed [55:0] s_cl;
  logic               s_sat;
  logic [46:0]        s_mag;
  logic [31:0]        d_mag;
  always_comb begin
    s_sat = 1'b0;
    s_cl  = acc_q;
    if (acc_q > S_MAX) begin
      s_cl  = S_MAX;
      s_sat = 1'b1;
    end else if (acc_q < S_MIN) begin
      s_cl  = S_MIN;
      s_sat = 1'b1;
    end
    s_mag = s_cl[55] ? 47'(-s_cl) : 47'(s_cl);
    d_mag = diag_q[31] ? 32'(-diag_q) : 32'(diag_q);
  end

  assign div_req.start    = (st_q == ST_CHK) && (diag_q != 0);
  assign div_req.dividend = {s_mag, 16'd0};
  assign div_req.divisor  = d_mag;

  // saturate the quotient into a q16.16 value
  logic        r_sat;
  always_comb begin
    r_sat = 1'b0;
    if (neg_q) begin
      if (div_rsp.quotient > 63'h8000_0000) begin
        r_sat = 1'b1;
        r_d   = Q_MIN;
      end else begin
        r_d = 32'(-div_rsp.quotient[31:0]);
      end
    end else if (div_rsp.quotient > 63'h7fff_ffff) begin
      r_sat = 1'b1;
      r_d   = Q_MAX;
    end else begin
      r_d = div_rsp.quotient[31:0];
    end
  end

  // final sum
  logic signed [55:0] lsum;
  assign lsum = $signed({2'b00, mahal_q[54:1]}) + 56'(off_rd) + 56'(l2p_q);

  // sequencer
  always_comb begin
    st_d    = st_q;
    i_d     = i_q;
    j_d     = j_q;
    acc_d   = acc_q;
    diag_d  = diag_q;
    prod_d  = prod_q;
    mahal_d = mahal_q;
    sat_d   = sat_q;
    neg_d   = neg_q;
    rv_d    = 1'b0;
    res_d   = res_q;
    unique case (st_q)
      ST_IDLE: begin
        if (is_eval) begin
          res_d.cluster_out = item_i.cluster;
          if (do_skip) begin
            res_d.logp    = item_i.prev_self;
            res_d.skipped = 1'b1;
            res_d.fault   = FAULT_OK;
            rv_d          = 1'b1;
          end else begin
            i_d     = '0;
            mahal_d = '0;
            sat_d   = 1'b0;
            st_d    = (n_w == '0) ? ST_FIN : ST_ROW;
          end
        end
      end
      ST_ROW: st_d = ST_ROWD;
      ST_ROWD: begin
        acc_d  = 56'(pt_rd) - 56'(mean_rd);
        diag_d = fac_rd;
        j_d    = '0;
        st_d   = (i_q == '0) ? ST_CHK : ST_MUL;
      end
      ST_MUL: begin
        prod_d = fac_rd * sol_rd;
        st_d   = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q - 56'(prod_q >>> 16);
        j_d   = j_q + 1'b1;
        st_d  = (IW'(j_q + 1'b1) == i_q) ? ST_CHK : ST_MUL;
      end
      ST_CHK: begin
        if (diag_q == 0) begin
          res_d.logp    = Q_MAX;
          res_d.skipped = 1'b0;
          res_d.fault   = FAULT_ZERO_DIAG;
          rv_d          = 1'b1;
          st_d          = ST_IDLE;
        end else begin
          sat_d = sat_q | s_sat;
          neg_d = s_cl[55] ^ diag_q[31];
          st_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          st_d = ST_SQ;
        end
      end
      ST_SQ: begin
        sat_d = sat_q | r_sat;
        st_d  = ST_SQM;
      end
      ST_SQM: begin
        prod_d = r_q * r_q;
        st_d   = ST_SQA;
      end
      ST_SQA: begin
        mahal_d = mahal_q + 55'(prod_q[63:16]);
        i_d     = i_q + 1'b1;
        st_d    = (IW'(i_q + 1'b1) == n_w) ? ST_FIN : ST_ROW;
      end
      ST_FIN: begin
        res_d.skipped = 1'b0;
        if (lsum > 56'(Q_MAX)) begin
          res_d.logp  = Q_MAX;
          res_d.fault = FAULT_SAT;
        end else if (lsum < 56'(Q_MIN)) begin
          res_d.logp  = Q_MIN;
          res_d.fault = FAULT_SAT;
        end else begin
          res_d.logp  = lsum[31:0];
          res_d.fault = sat_q ? FAULT_SAT : FAULT_OK;
        end
        rv_d = 1'b1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    diag_q  <= diag_d;
    prod_q  <= prod_d;
    mahal_q <= mahal_d;
    neg_q   <= neg_d;
    res_q   <= res_d;
    if (st_q == ST_SQ) begin
      r_q <= r_d;
    end
    if (is_eval) begin
      cl_q <= item_i.cluster;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      i_q   <= '0;
      j_q   <= '0;
      sat_q <= 1'b0;
      rv_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      i_q   <= i_d;
      j_q   <= j_d;
      sat_q <= sat_d;
      rv_q  <= rv_d;
    end
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  // a zero diagonal always reports the positive limit
  a_zero_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.fault == FAULT_ZERO_DIAG |-> result_o.logp == Q_MAX)
    else $error("zero diagonal result without positive limit");

  // a skipped beat carries no fault
  a_skip_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.skipped |-> result_o.fault == FAULT_OK)
    else $error("skipped result with fault");

  // divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> st_q == ST_DIV)
    else $error("divider finished outside divide state");

  // a full evaluate keeps the block busy
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_eval && !do_skip |=> busy_o)
    else $error("evaluate accepted without going busy");

endmodule
`default_nettype wire

/* design/gcll_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module gcll_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* design/gcll_div.sv */
// restoring divider, one quotient bit per cycle, unsigned 63 by 32 bits
`default_nettype none
module gcll_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gcll_pkg::div_req_t  req_i,
  output gcll_pkg::div_rsp_t       rsp_o
);
  import gcll_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [62:0] quo_q, quo_d;
  logic [31:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  // one restoring step
  always_comb begin
    trial  = {rem_q, quo_q[62]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      div_d = req_i.divisor;
      cnt_d = 6'd62;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = 32'(trial - {1'b0, div_q});
        quo_d = {quo_q[61:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[61:0], 1'b0};
      end
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire
